// ===== rtl/csf_pkg.sv =====
// Shared types and constants for the context store forwarding block.
package csf_pkg;

  localparam int FUNC_W   = 3;
  localparam int OFFSET_W = 16;
  localparam int SIZE_W   = 8;
  localparam int FLAG_W   = 5;
  localparam int TAG_W    = 16;
  localparam int BASE_W   = 16;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 1;

  // Index carried through the queue; wide enough for any register or flag number.
  localparam int IDX_W = FLAG_W;

  // GPR slots are 8 bytes apart, vector slots 16.
  localparam int GPR_SHIFT = 3;
  localparam int VEC_SHIFT = 4;
  localparam int GPR_STRIDE = 1 << GPR_SHIFT;
  localparam int VEC_STRIDE = 1 << VEC_SHIFT;

  localparam logic [BASE_W-1:0] GPR_BASE_RST = 16'd8;
  localparam logic [BASE_W-1:0] VEC_BASE_RST = 16'd144;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GPR_BASE = 1'b0,
    REG_VEC_BASE = 1'b1
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_STORE_CTX  = 3'd0,
    FUNC_LOAD_CTX   = 3'd1,
    FUNC_STORE_FLAG = 3'd2,
    FUNC_LOAD_FLAG  = 3'd3,
    FUNC_OTHER      = 3'd4
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_DIRECT  = 2'd1,
    KIND_BITCAST = 2'd2,
    KIND_EXTRACT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BANK_NONE = 2'd0,
    BANK_GPR  = 2'd1,
    BANK_VEC  = 2'd2,
    BANK_FLAG = 2'd3
  } bank_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_STORE = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_KILL  = 2'd3
  } act_t;

  // Decoded access, one queue entry.
  typedef struct packed {
    logic             new_block;
    bank_t            bank;
    act_t             act;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== rtl/csf_front.sv =====
// Front end: base registers and access decode into bank, action and index.
module csf_front #(
  parameter int NUM_REGS  = 16,
  parameter int NUM_FLAGS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [csf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csf_pkg::BASE_W-1:0]     cfg_data,
  input  logic [csf_pkg::FUNC_W-1:0]     func,
  input  logic                           new_block,
  input  logic [csf_pkg::OFFSET_W-1:0]   offset,
  input  logic [csf_pkg::SIZE_W-1:0]     access_size,
  input  logic [csf_pkg::FLAG_W-1:0]     flag_index,
  input  logic [csf_pkg::TAG_W-1:0]      value_tag,
  output csf_pkg::op_t                   op
);
  import csf_pkg::*;

  localparam logic [BASE_W:0] GPR_SPAN = (BASE_W+1)'(GPR_STRIDE * (NUM_REGS - 1));
  localparam logic [BASE_W:0] VEC_SPAN = (BASE_W+1)'(VEC_STRIDE * (NUM_REGS - 1));

  logic [BASE_W-1:0] gpr_base;
  logic [BASE_W-1:0] vec_base;

  logic [BASE_W:0]   gpr_top, vec_top;
  logic [BASE_W-1:0] gpr_delta, vec_delta;
  logic              gpr_hit, vec_hit, gpr_full, vec_full, flag_ok, is_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      gpr_base <= GPR_BASE_RST;
      vec_base <= VEC_BASE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GPR_BASE: gpr_base <= cfg_data;
        REG_VEC_BASE: vec_base <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gpr_top   = {1'b0, gpr_base} + GPR_SPAN;
  assign vec_top   = {1'b0, vec_base} + VEC_SPAN;
  assign gpr_hit   = (offset >= gpr_base) && ({1'b0, offset} <= gpr_top);
  assign vec_hit   = (offset >= vec_base) && ({1'b0, offset} <= vec_top);
  assign gpr_delta = offset - gpr_base;
  assign vec_delta = offset - vec_base;
  assign gpr_full  = (access_size == SIZE_W'(GPR_STRIDE)) &&
                     (offset[GPR_SHIFT-1:0] == '0);
  assign vec_full  = (access_size == SIZE_W'(VEC_STRIDE)) &&
                     (offset[VEC_SHIFT-1:0] == '0);
  assign flag_ok   = {2'b00, flag_index} < (FLAG_W+2)'(NUM_FLAGS);
  assign is_store  = (func == FUNC_STORE_CTX);

  always_comb begin
    op           = '0;
    op.new_block = new_block;
    op.tag       = value_tag;
    op.bank      = BANK_NONE;
    op.act       = ACT_NONE;
    unique case (func)
      FUNC_STORE_CTX, FUNC_LOAD_CTX: begin
        // GPR range wins where the two ranges overlap
        if (gpr_hit) begin
          op.bank = BANK_GPR;
          op.idx  = gpr_delta[GPR_SHIFT +: IDX_W];
          op.act  = !gpr_full ? ACT_KILL : (is_store ? ACT_STORE : ACT_LOAD);
        end else if (vec_hit) begin
          op.bank = BANK_VEC;
          op.idx  = vec_delta[VEC_SHIFT +: IDX_W];
          op.act  = !vec_full ? ACT_KILL : (is_store ? ACT_STORE : ACT_LOAD);
        end
      end
      FUNC_STORE_FLAG, FUNC_LOAD_FLAG: begin
        if (flag_ok) begin
          op.bank = BANK_FLAG;
          op.idx  = flag_index;
          op.act  = (func == FUNC_STORE_FLAG) ? ACT_STORE : ACT_LOAD;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/csf_queue.sv =====
// Short FIFO of decoded accesses between front and back.
module csf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  csf_pkg::op_t         push_op,
  input  logic                 pop,
  output csf_pkg::op_t         head_op,
  output csf_pkg::queue_stat_t stat
);
  import csf_pkg::*;

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_op;
  end

  assign head_op    = mem[rd_ptr];
  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== rtl/csf_back.sv =====
// Back end: entry tables, forwarding lookup and output register.
module csf_back #(
  parameter int NUM_REGS  = 16,
  parameter int NUM_FLAGS = 32,
  parameter int TAG_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  csf_pkg::op_t                op,
  input  csf_pkg::queue_stat_t        q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [csf_pkg::KIND_W-1:0]  forward_kind,
  output logic [csf_pkg::TAG_W-1:0]   forward_tag
);
  import csf_pkg::*;

  localparam int REG_IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int FLAG_IDX_W = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;

  logic [NUM_REGS-1:0]  gpr_valid, gpr_valid_next;
  logic [NUM_REGS-1:0]  vec_valid, vec_valid_next;
  logic [NUM_FLAGS-1:0] flag_valid, flag_valid_next;
  logic [TAG_BITS-1:0]  gpr_tag  [NUM_REGS];
  logic [TAG_BITS-1:0]  vec_tag  [NUM_REGS];
  logic [TAG_BITS-1:0]  flag_tag [NUM_FLAGS];

  logic [REG_IDX_W-1:0]  reg_sel;
  logic [FLAG_IDX_W-1:0] flag_sel;
  logic [31:0]           tag_wide, rd_wide;
  logic [TAG_BITS-1:0]   store_tag, rd_tag;
  logic                  hit, set_bit, clr_bit;
  kind_t                 kind;
  logic [TAG_W-1:0]      fwd_tag;

  assign reg_sel   = REG_IDX_W'(op.idx);
  assign flag_sel  = FLAG_IDX_W'(op.idx);
  assign tag_wide  = 32'(op.tag);
  assign store_tag = tag_wide[TAG_BITS-1:0];
  assign set_bit   = (op.act == ACT_STORE);
  assign clr_bit   = (op.act == ACT_LOAD) || (op.act == ACT_KILL);
  assign pop       = !q_stat.empty && (!out_valid || !out_stall);

  // Lookup; a block start masks every entry
  always_comb begin
    hit    = 1'b0;
    rd_tag = '0;
    kind   = KIND_NONE;
    unique case (op.bank)
      BANK_GPR: begin
        hit    = gpr_valid[reg_sel];
        rd_tag = gpr_tag[reg_sel];
        kind   = KIND_DIRECT;
      end
      BANK_VEC: begin
        hit    = vec_valid[reg_sel];
        rd_tag = vec_tag[reg_sel];
        kind   = KIND_BITCAST;
      end
      BANK_FLAG: begin
        hit    = flag_valid[flag_sel];
        rd_tag = flag_tag[flag_sel];
        kind   = KIND_EXTRACT;
      end
      BANK_NONE: ;
    endcase
    hit = hit && !op.new_block && (op.act == ACT_LOAD);
    if (!hit) kind = KIND_NONE;
  end

  assign rd_wide = 32'(rd_tag);
  assign fwd_tag = hit ? rd_wide[TAG_W-1:0] : '0;

  always_comb begin
    gpr_valid_next  = op.new_block ? '0 : gpr_valid;
    vec_valid_next  = op.new_block ? '0 : vec_valid;
    flag_valid_next = op.new_block ? '0 : flag_valid;
    if (op.bank == BANK_GPR) begin
      if (set_bit) gpr_valid_next[reg_sel] = 1'b1;
      if (clr_bit) gpr_valid_next[reg_sel] = 1'b0;
    end
    if (op.bank == BANK_VEC) begin
      if (set_bit) vec_valid_next[reg_sel] = 1'b1;
      if (clr_bit) vec_valid_next[reg_sel] = 1'b0;
    end
    if (op.bank == BANK_FLAG) begin
      if (set_bit) flag_valid_next[flag_sel] = 1'b1;
      if (clr_bit) flag_valid_next[flag_sel] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gpr_valid  <= '0;
      vec_valid  <= '0;
      flag_valid <= '0;
    end else if (pop) begin
      gpr_valid  <= gpr_valid_next;
      vec_valid  <= vec_valid_next;
      flag_valid <= flag_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && set_bit) begin
      if (op.bank == BANK_GPR)  gpr_tag[reg_sel]   <= store_tag;
      if (op.bank == BANK_VEC)  vec_tag[reg_sel]   <= store_tag;
      if (op.bank == BANK_FLAG) flag_tag[flag_sel] <= store_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      forward_kind <= kind;
      forward_tag  <= fwd_tag;
    end
  end

endmodule

// ===== rtl/context_store_load_forwarding.sv =====
// Top level of the context store-to-load forwarding block.
//
// Input channel (in_valid / in_stall) takes one context access per beat: a
// context store or load at a byte offset and size, a flag store or load, or
// another op. Every input beat yields exactly one output beat on the
// out_valid / out_stall channel: forward_kind and forward_tag, zero when the
// access is not answered from a tracked entry.
// gpr_base and vec_base are written through cfg_write / cfg_index / cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Throughput: one beat per cycle while the output is not stalled; decode is
// combinational, and each pop does the single table read-modify-write in the
// back end and loads the output register.
// An input beat passes through the decode queue, then the output register,
// on its way to the output beat.
// Reset (rst, synchronous) invalidates every entry, empties the queue and
// restores gpr_base = 8, vec_base = 144.
// A stalled output holds its beat; the back end stops draining the queue and
// in_stall rises once the 2-entry queue fills.
module context_store_load_forwarding #(
  parameter int NUM_REGS  = 16,
  parameter int NUM_FLAGS = 32,
  parameter int TAG_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [csf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csf_pkg::BASE_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [csf_pkg::FUNC_W-1:0]     func,
  input  logic                           new_block,
  input  logic [csf_pkg::OFFSET_W-1:0]   offset,
  input  logic [csf_pkg::SIZE_W-1:0]     access_size,
  input  logic [csf_pkg::FLAG_W-1:0]     flag_index,
  input  logic [csf_pkg::TAG_W-1:0]      value_tag,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [csf_pkg::KIND_W-1:0]     forward_kind,
  output logic [csf_pkg::TAG_W-1:0]      forward_tag
);
  import csf_pkg::*;

  op_t         dec_op;   // decoded access from the front end
  op_t         head_op;  // oldest queued access
  queue_stat_t q_stat;
  logic        push, pop;

  // Queue full is the only backpressure on the input side
  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall;

  csf_front #(
    .NUM_REGS  (NUM_REGS),
    .NUM_FLAGS (NUM_FLAGS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .new_block   (new_block),
    .offset      (offset),
    .access_size (access_size),
    .flag_index  (flag_index),
    .value_tag   (value_tag),
    .op          (dec_op)
  );

  csf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (dec_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  // Back end drains the queue whenever the output register is free or leaving
  csf_back #(
    .NUM_REGS  (NUM_REGS),
    .NUM_FLAGS (NUM_FLAGS),
    .TAG_BITS  (TAG_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op           (head_op),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .forward_kind (forward_kind),
    .forward_tag  (forward_tag)
  );

  // An accepted beat is in the queue in the cycle after the push
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> !q_stat.empty)
    else $error("accepted beat missing from queue");

  // No forward means a zero tag
  a_none_zero_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && forward_kind == KIND_NONE) |-> (forward_tag == '0))
    else $error("tag present without a forward");

  // An output beat only goes away once taken
  a_beat_not_dropped: assert property (@(posedge clk) disable iff (rst)
    ($fell(out_valid) && !$past(rst)) |-> !$past(out_stall))
    else $error("output beat dropped while stalled");

  // Queue is never popped empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
